// File: sv/is_pkg.sv
// Shared types and constants for the insertion sorter.
package is_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // Command and broadcast value sent to every cell.
  typedef struct packed {
    logic  ins;
    logic  shift;
    data_t value;
  } cell_ctl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic  vld;
    logic  gt;
    data_t value;
  } cell_st_t;

endpackage

// File: sv/is_chan_if.sv
// Stream interfaces for the input and result channels.
interface is_in_if;
  logic             valid;
  logic             ready;
  is_pkg::data_t    value;
  logic             batch_end;

  modport source (output valid, output value, output batch_end, input ready);
  modport sink   (input valid, input value, input batch_end, output ready);
endinterface

interface is_out_if;
  logic             valid;
  logic             ready;
  is_pkg::data_t    sorted_value;
  logic             final_res;
  logic             overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input final_res, input overflow,
                  output ready);
endinterface

// File: sv/is_cell.sv
// One cell of the sorting chain: holds one entry and its valid bit.
module is_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  is_pkg::cell_ctl_t ctl,
  input  is_pkg::cell_st_t  left,
  input  is_pkg::cell_st_t  right,
  output is_pkg::cell_st_t  st
);
  import is_pkg::*;

  logic  vld_r, vld_nxt;
  data_t value_r, value_nxt;
  logic  gt;

  // An empty cell acts as +infinity so the new entry lands at the fill edge.
  assign gt = !vld_r || (value_r > ctl.value);

  always_comb begin
    vld_nxt   = vld_r;
    value_nxt = value_r;
    if (ctl.ins && gt) begin
      if (left.gt) begin
        vld_nxt   = left.vld;
        value_nxt = left.value;
      end else begin
        vld_nxt   = 1'b1;
        value_nxt = ctl.value;
      end
    end else if (ctl.shift) begin
      vld_nxt   = right.vld;
      value_nxt = right.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign st.vld   = vld_r;
  assign st.gt    = gt;
  assign st.value = value_r;

endmodule

// File: sv/insertion_sorter.sv
// Insertion sorter top level: a chain of compare-and-shift cells with batch drain control.
// An accepted word is registered into its sorted slot by the edge that ends its accept cycle.
// Throughput: one input word per cycle while a batch fills; after the word marked
//   batch_end, the first result appears in the next cycle and the batch of n entries
//   drains at one word per cycle while out_ch is ready; input is held off during the
//   drain. The drain rate is set by the cells shifting down the chain.
// Reset (synchronous, rst_n low) clears all cell valid bits, the drop flag and drain state.
module insertion_sorter #(
  parameter int CAPACITY = is_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  is_in_if.sink      in_ch,
  is_out_if.source   out_ch
);
  import is_pkg::*;

  cell_ctl_t ctl;
  cell_st_t  st [CAPACITY];

  logic drain_r, drain_nxt;
  logic dropped_r, dropped_nxt;
  logic in_fire, out_fire, full, last_word;

  // Take new words only while filling; the chain is busy shifting out otherwise.
  assign in_ch.ready = !drain_r;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // The top cell holds an entry only when the store is full.
  assign full = st[CAPACITY-1].vld;

  // Broadcast the incoming word; insert unless full (then drop it).
  assign ctl.ins   = in_fire && !full;
  assign ctl.shift = out_fire;
  assign ctl.value = in_ch.value;

  // Cell 0 always holds the smallest remaining entry during a drain.
  assign out_ch.valid        = drain_r;
  assign out_ch.sorted_value = st[0].value;
  assign last_word           = !st[1].vld;
  assign out_ch.final_res    = last_word;
  assign out_ch.overflow     = dropped_r;
  assign out_fire            = out_ch.valid && out_ch.ready;

  always_comb begin
    drain_nxt   = drain_r;
    dropped_nxt = dropped_r;
    if (in_fire) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end
      if (in_ch.batch_end) begin
        drain_nxt = 1'b1;
      end
    end
    // Close the batch once its final word has been taken.
    if (out_fire && last_word) begin
      drain_nxt   = 1'b0;
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r   <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      drain_r   <= drain_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // Chain of cells: each sees its lower neighbor for insertion and its upper for draining.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_st_t left_st, right_st;

    if (i == 0) begin : g_first
      assign left_st = '0;
    end else begin : g_mid_lo
      assign left_st = st[i-1];
    end

    if (i == CAPACITY-1) begin : g_last
      assign right_st = '0;
    end else begin : g_mid_hi
      assign right_st = st[i+1];
    end

    is_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .left  (left_st),
      .right (right_st),
      .st    (st[i])
    );
  end

endmodule
